FILE: rtl/kth_unused_slot_take_unit_macros.svh
// Assertion macros for the slot take unit checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef KTH_UNUSED_SLOT_TAKE_UNIT_MACROS_SVH
`define KTH_UNUSED_SLOT_TAKE_UNIT_MACROS_SVH

// Antecedent holds, consequent holds in the same cycle.
`define KUT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent holds, consequent holds in the next cycle.
`define KUT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/kut_pkg.sv
// Shared constants, types and helper functions of the slot take unit.
// No dependencies.
package kut_pkg;

  localparam int STORE_BYTES = 1024;
  localparam int BLOCK_SLOTS = 1024;
  localparam int TOTAL_SLOTS = STORE_BYTES * 4;
  localparam int NUM_BLOCKS  = (TOTAL_SLOTS + BLOCK_SLOTS - 1) / BLOCK_SLOTS;
  localparam int BLOCK_BYTES = BLOCK_SLOTS / 4;

  localparam int ADDR_W = 10;
  localparam int BLK_W  = 2;
  localparam int BB_W   = 8;
  localparam int CNT_W  = 11;
  localparam int SLOT_W = 12;
  localparam int SC_W   = 13;

  localparam logic [1:0] FUNC_LOAD     = 2'd0;
  localparam logic [1:0] FUNC_TAKE_VAL = 2'd1;
  localparam logic [1:0] FUNC_TAKE_IDX = 2'd2;

  localparam logic [7:0] VALUE_MASK = 8'h55;

  typedef struct packed {
    logic clr;
    logic cap;
    logic cfg_wr;
    logic ld_wr;
    logic sel;
    logic walk;
    logic rc_acc;
    logic ptr_inc;
  } kut_cmd_t;

  typedef struct packed {
    logic in_range;
    logic hit;
    logic block_end;
    logic sweep_end;
    logic clr_end;
  } kut_sts_t;

  function automatic logic [3:0] used_mask(input logic [7:0] b);
    used_mask = {b[7], b[5], b[3], b[1]};
  endfunction

  // Slots of a byte that lie below the valid slot count.
  function automatic logic [3:0] valid_mask(input logic [ADDR_W-1:0] a,
                                            input logic [SC_W-1:0] n);
    logic [SC_W-1:0] s;
    valid_mask = '0;
    for (int p = 0; p < 4; p++) begin
      s = {1'b0, a, 2'(p)};
      valid_mask[p] = (s < n);
    end
  endfunction

  function automatic logic [2:0] pop4(input logic [3:0] m);
    pop4 = 3'({2'b0, m[0]}) + 3'({2'b0, m[1]}) + 3'({2'b0, m[2]}) + 3'({2'b0, m[3]});
  endfunction

endpackage

FILE: rtl/kut_ram.sv
// Generic single write port RAM with one registered read port.
// No dependencies.
module kut_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/kut_datapath.sv
// Datapath: slot store RAM, per-block unused counts, rank search and result register.
// Depends on kut_pkg and kut_ram.
module kut_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  kut_pkg::kut_cmd_t           cmd,
  input  logic [1:0]                  in_func,
  input  logic [kut_pkg::ADDR_W-1:0]  in_byte_address,
  input  logic [7:0]                  in_load_byte,
  input  logic [kut_pkg::SLOT_W-1:0]  in_rank,
  input  logic [kut_pkg::SC_W-1:0]    cfg_slot_count,
  output kut_pkg::kut_sts_t           sts,
  output logic                        out_strobe,
  output logic                        out_found,
  output logic                        out_value_bit,
  output logic [kut_pkg::SLOT_W-1:0]  out_slot_index
);
  import kut_pkg::*;

  logic [SC_W-1:0]   sc_r, sc_nxt;
  logic [CNT_W-1:0]  counts_r [NUM_BLOCKS];
  logic [CNT_W-1:0]  counts_nxt [NUM_BLOCKS];
  logic [1:0]        func_r, func_nxt;
  logic [SLOT_W-1:0] k_r, k_nxt;
  logic [7:0]        lbyte_r, lbyte_nxt;
  logic [ADDR_W-1:0] ptr_r, ptr_nxt;
  logic [ADDR_W-1:0] chk_r;
  logic [BLK_W-1:0]  blk_r, blk_nxt;
  logic              strobe_r, strobe_nxt;
  logic              found_r, found_nxt;
  logic              value_r, value_nxt;
  logic [SLOT_W-1:0] index_r, index_nxt;

  logic [SC_W-1:0]   n_valid;
  logic [7:0]        rdata;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;

  logic [SC_W-1:0]   total;
  logic [SC_W-1:0]   rem;
  logic [SC_W-1:0]   rem_sel;
  logic [BLK_W-1:0]  sel_b;
  logic              sel_done;

  logic [3:0]        free_m;
  logic [2:0]        free_cnt;
  logic [2:0]        run;
  logic [1:0]        pos;
  logic              hit;
  logic [BLK_W-1:0]  chk_blk;
  logic [BLK_W-1:0]  ptr_blk;

  assign n_valid = (sc_r > SC_W'(TOTAL_SLOTS)) ? SC_W'(TOTAL_SLOTS) : sc_r;
  assign chk_blk = chk_r[ADDR_W-1 -: BLK_W];
  assign ptr_blk = ptr_r[ADDR_W-1 -: BLK_W];

  kut_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ptr_r),
    .rdata (rdata)
  );

  // Block pick: the rank is walked down through the four block counts.
  always_comb begin
    total    = '0;
    rem      = {1'b0, k_r};
    rem_sel  = '0;
    sel_b    = '0;
    sel_done = 1'b0;
    for (int b = 0; b < NUM_BLOCKS; b++) begin
      total = total + SC_W'(counts_r[b]);
      if (!sel_done) begin
        if (rem < SC_W'(counts_r[b])) begin
          sel_b    = BLK_W'(b);
          rem_sel  = rem;
          sel_done = 1'b1;
        end else begin
          rem = rem - SC_W'(counts_r[b]);
        end
      end
    end
  end

  // Byte check during the slot walk and the recount sweep.
  always_comb begin
    free_m   = ~used_mask(rdata) & valid_mask(chk_r, n_valid);
    free_cnt = pop4(free_m);
    hit      = (k_r < SLOT_W'(free_cnt));
    run      = '0;
    pos      = '0;
    for (int p = 0; p < 4; p++) begin
      if (free_m[p]) begin
        if (SLOT_W'(run) == k_r) begin
          pos = 2'(p);
        end
        run = run + 3'd1;
      end
    end
  end

  assign sts.in_range  = ({1'b0, k_r} < total);
  assign sts.hit       = hit;
  assign sts.block_end = (chk_r[BB_W-1:0] == {BB_W{1'b1}});
  assign sts.sweep_end = (chk_r == {ADDR_W{1'b1}});
  assign sts.clr_end   = (ptr_r == {ADDR_W{1'b1}});

  // The clearing pass after reset zeroes the store one byte per cycle.
  assign ram_we    = cmd.clr | cmd.ld_wr | (cmd.walk & hit);
  assign ram_waddr = (cmd.clr | cmd.ld_wr) ? ptr_r : chk_r;
  assign ram_wdata = cmd.clr   ? 8'h00 :
                     cmd.ld_wr ? (lbyte_r & VALUE_MASK) :
                                 (rdata | (8'b10 << {pos, 1'b0}));

  always_comb begin
    sc_nxt     = sc_r;
    counts_nxt = counts_r;
    func_nxt   = func_r;
    k_nxt      = k_r;
    lbyte_nxt  = lbyte_r;
    blk_nxt    = blk_r;
    ptr_nxt    = ptr_r;
    strobe_nxt = 1'b0;
    found_nxt  = found_r;
    value_nxt  = value_r;
    index_nxt  = index_r;

    if (cmd.cap) begin
      ptr_nxt   = in_byte_address;
      func_nxt  = in_func;
      k_nxt     = in_rank;
      lbyte_nxt = in_load_byte;
    end else if (cmd.sel) begin
      ptr_nxt = {sel_b, {BB_W{1'b0}}};
    end else if (cmd.cfg_wr) begin
      ptr_nxt = '0;
    end else if (cmd.ptr_inc) begin
      ptr_nxt = ptr_r + ADDR_W'(1);
    end

    if (cmd.cfg_wr) begin
      sc_nxt = cfg_slot_count;
      for (int b = 0; b < NUM_BLOCKS; b++) begin
        counts_nxt[b] = '0;
      end
    end

    // Clearing a used mark of a valid slot returns it to its block.
    if (cmd.ld_wr) begin
      counts_nxt[ptr_blk] = counts_r[ptr_blk]
        + CNT_W'(pop4(used_mask(rdata) & valid_mask(ptr_r, n_valid)));
    end

    if (cmd.sel) begin
      k_nxt   = rem_sel[SLOT_W-1:0];
      blk_nxt = sel_b;
      if (!sts.in_range) begin
        strobe_nxt = 1'b1;
        found_nxt  = 1'b0;
        value_nxt  = 1'b0;
        index_nxt  = '0;
      end
    end

    if (cmd.walk) begin
      if (hit) begin
        counts_nxt[blk_r] = counts_r[blk_r] - CNT_W'(1);
        strobe_nxt = 1'b1;
        found_nxt  = 1'b1;
        value_nxt  = (func_r == FUNC_TAKE_VAL) ? rdata[{pos, 1'b0}] : 1'b0;
        index_nxt  = (func_r == FUNC_TAKE_IDX) ? {chk_r, pos} : '0;
      end else if (sts.block_end) begin
        strobe_nxt = 1'b1;
        found_nxt  = 1'b0;
        value_nxt  = 1'b0;
        index_nxt  = '0;
      end else begin
        k_nxt = k_r - SLOT_W'(free_cnt);
      end
    end

    if (cmd.rc_acc) begin
      counts_nxt[chk_blk] = counts_r[chk_blk] + CNT_W'(free_cnt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_r     <= SC_W'(TOTAL_SLOTS);
      strobe_r <= 1'b0;
      ptr_r    <= '0;
      for (int b = 0; b < NUM_BLOCKS; b++) begin
        counts_r[b] <= CNT_W'(BLOCK_SLOTS);
      end
    end else begin
      sc_r     <= sc_nxt;
      strobe_r <= strobe_nxt;
      ptr_r    <= ptr_nxt;
      counts_r <= counts_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r  <= func_nxt;
    k_r     <= k_nxt;
    lbyte_r <= lbyte_nxt;
    blk_r   <= blk_nxt;
    chk_r   <= ptr_r;
    found_r <= found_nxt;
    value_r <= value_nxt;
    index_r <= index_nxt;
  end

  assign out_strobe     = strobe_r;
  assign out_found      = found_r;
  assign out_value_bit  = value_r;
  assign out_slot_index = index_r;

endmodule

FILE: rtl/kut_ctrl.sv
// Controller state machine: sequences loads, takes, the block recount and the clearing pass after reset.
// Depends on kut_pkg.
module kut_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        in_func,
  input  logic              cfg_valid,
  input  kut_pkg::kut_sts_t sts,
  output kut_pkg::kut_cmd_t cmd,
  output logic              busy,
  output logic              cfg_ready
);
  import kut_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_LD_RD   = 4'd1;
  localparam logic [3:0] S_LD_WR   = 4'd2;
  localparam logic [3:0] S_TK_SEL  = 4'd3;
  localparam logic [3:0] S_TK_FILL = 4'd4;
  localparam logic [3:0] S_WALK    = 4'd5;
  localparam logic [3:0] S_RC_FILL = 4'd6;
  localparam logic [3:0] S_RC      = 4'd7;
  localparam logic [3:0] S_CLR     = 4'd8;

  logic [3:0] state_r, state_nxt;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE) && !start;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (cfg_valid && !start) begin
          cmd.cfg_wr = 1'b1;
          state_nxt  = S_RC_FILL;
        end else if (start) begin
          cmd.cap = 1'b1;
          if (in_func == FUNC_LOAD) begin
            state_nxt = S_LD_RD;
          end else if (in_func == FUNC_TAKE_VAL || in_func == FUNC_TAKE_IDX) begin
            state_nxt = S_TK_SEL;
          end
        end
      end
      S_LD_RD: begin
        state_nxt = S_LD_WR;
      end
      S_LD_WR: begin
        cmd.ld_wr = 1'b1;
        state_nxt = S_IDLE;
      end
      S_TK_SEL: begin
        cmd.sel   = 1'b1;
        state_nxt = sts.in_range ? S_TK_FILL : S_IDLE;
      end
      S_TK_FILL: begin
        cmd.ptr_inc = 1'b1;
        state_nxt   = S_WALK;
      end
      S_WALK: begin
        cmd.walk    = 1'b1;
        cmd.ptr_inc = 1'b1;
        if (sts.hit || sts.block_end) begin
          state_nxt = S_IDLE;
        end
      end
      S_RC_FILL: begin
        cmd.ptr_inc = 1'b1;
        state_nxt   = S_RC;
      end
      S_RC: begin
        cmd.rc_acc  = 1'b1;
        cmd.ptr_inc = 1'b1;
        if (sts.sweep_end) begin
          state_nxt = S_IDLE;
        end
      end
      S_CLR: begin
        cmd.clr     = 1'b1;
        cmd.ptr_inc = 1'b1;
        if (sts.clr_end) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/kth_unused_slot_take_unit.sv
// Top level of the slot take unit: controller plus datapath.
// Depends on kut_pkg, kut_ctrl, kut_datapath (and kut_ram below it).
//
// Usage:
//   A word is accepted on a clock edge with start high and busy low. func 0 loads
//   one byte of value bits and clears that byte's used marks, no result word.
//   func 1 and 2 take the rank-th unused slot and give one result word: found,
//   then the value bit (func 1) or the slot index (func 2); func 3 is dropped.
//   Results appear on out_* for one cycle with out_strobe high and cannot be
//   stalled; the unit never waits on the receiver.
//   A load keeps busy through a read state and a write state. A take first checks
//   the four block counts and then walks the chosen block one byte per cycle
//   through the store RAM read port until it finds the slot or reaches the block end.
//   A rank at or beyond the unused count gives found 0 from the block check, with no walk.
//   cfg_slot_count is written with cfg_valid and cfg_ready; the write recounts
//   all blocks by sweeping the store, and busy stays high for the whole sweep.
//   After reset busy stays high while the store is cleared to zero;
//   the slot count is 4096 and every block counts all its slots as unused.
module kth_unused_slot_take_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_func,
  input  logic [kut_pkg::ADDR_W-1:0] in_byte_address,
  input  logic [7:0]                 in_load_byte,
  input  logic [kut_pkg::SLOT_W-1:0] in_rank,
  output logic                       out_strobe,
  output logic                       out_found,
  output logic                       out_value_bit,
  output logic [kut_pkg::SLOT_W-1:0] out_slot_index,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [kut_pkg::SC_W-1:0]   cfg_slot_count
);
  import kut_pkg::*;

  kut_cmd_t cmd;
  kut_sts_t sts;

  kut_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_func   (in_func),
    .cfg_valid (cfg_valid),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .cfg_ready (cfg_ready)
  );

  kut_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_func         (in_func),
    .in_byte_address (in_byte_address),
    .in_load_byte    (in_load_byte),
    .in_rank         (in_rank),
    .cfg_slot_count  (cfg_slot_count),
    .sts             (sts),
    .out_strobe      (out_strobe),
    .out_found       (out_found),
    .out_value_bit   (out_value_bit),
    .out_slot_index  (out_slot_index)
  );

endmodule

FILE: rtl/kut_checker.sv
// Port-level checker for the slot take unit, bound to the top level.
// Depends on kut_pkg and kth_unused_slot_take_unit_macros.svh.
`include "kth_unused_slot_take_unit_macros.svh"

module kut_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic [1:0]                 in_func,
  input logic                       out_strobe,
  input logic                       out_found,
  input logic                       out_value_bit,
  input logic [kut_pkg::SLOT_W-1:0] out_slot_index,
  input logic                       cfg_valid,
  input logic                       cfg_ready
);
  import kut_pkg::*;

  logic item_acc;
  logic miss_clean;

  assign item_acc   = start && !busy &&
                      (in_func == FUNC_LOAD || in_func == FUNC_TAKE_VAL ||
                       in_func == FUNC_TAKE_IDX);
  assign miss_clean = (out_slot_index == '0) && !out_value_bit;

  `KUT_ASSERT_NOW(a_strobe_idle, out_strobe, !busy, "result word while busy")
  `KUT_ASSERT_NEXT(a_strobe_single, out_strobe, !out_strobe, "result words back to back")
  `KUT_ASSERT_NOW(a_miss_zero, out_strobe && !out_found, miss_clean, "miss word not zero")
  `KUT_ASSERT_NEXT(a_item_busy, item_acc, busy, "accepted word did not make the unit busy")
  `KUT_ASSERT_NEXT(a_cfg_busy, cfg_valid && cfg_ready, busy, "config write did not start the recount")

endmodule

bind kth_unused_slot_take_unit kut_checker u_kut_checker (.*);

FILE: test/kth_unused_slot_take_unit_tb.sv
// Testbench for kth_unused_slot_take_unit: loads, rank takes and slot count writes,
// checked against a behavioral predictor of the slot store. Depends on kut_pkg and the RTL.
`timescale 1ns / 100ps

module kth_unused_slot_take_unit_tb;
  import kut_pkg::*;

  typedef struct {
    logic [1:0]        func;
    logic [ADDR_W-1:0] byte_address;
    logic [7:0]        load_byte;
    logic [SLOT_W-1:0] rank;
  } slot_word_t;

  typedef struct {
    logic              found;
    logic              value_bit;
    logic [SLOT_W-1:0] slot_index;
  } take_result_t;

  localparam int CYCLE_LIMIT = 1500000;
  localparam logic [1:0] FUNC_IGNORED = 2'd3;

  logic clk, rst_n, start, busy;
  logic [1:0]        in_func;
  logic [ADDR_W-1:0] in_byte_address;
  logic [7:0]        in_load_byte;
  logic [SLOT_W-1:0] in_rank;
  logic              out_strobe, out_found, out_value_bit;
  logic [SLOT_W-1:0] out_slot_index;
  logic              cfg_valid, cfg_ready;
  logic [SC_W-1:0]   cfg_slot_count;

  kth_unused_slot_take_unit u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_byte_address(in_byte_address),
    .in_load_byte(in_load_byte), .in_rank(in_rank),
    .out_strobe(out_strobe), .out_found(out_found),
    .out_value_bit(out_value_bit), .out_slot_index(out_slot_index),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_slot_count(cfg_slot_count)
  );

  slot_word_t   pending_words[$];
  take_result_t expected_takes[$];
  logic [7:0]   slot_image [STORE_BYTES];
  int           valid_slot_limit;
  int           sender_idle_pct;
  int           mismatches, takes_checked, takes_found, words_sent, cycle_count;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int unused_slots();
    int n;
    n = 0;
    for (int s = 0; s < valid_slot_limit; s++)
      if (!slot_image[s >> 2][2 * (s & 3) + 1]) n++;
    return n;
  endfunction

  // Applies one word to the slot image and queues the result a take should give.
  task automatic queue_word(input slot_word_t w);
    take_result_t r;
    int k, pos;
    pending_words.push_back(w);
    if (w.func == FUNC_LOAD) begin
      slot_image[w.byte_address] = w.load_byte & VALUE_MASK;
    end else if (w.func != FUNC_IGNORED) begin
      r = '{1'b0, 1'b0, '0};
      k = w.rank;
      for (int s = 0; s < valid_slot_limit; s++) begin
        pos = 2 * (s & 3);
        if (!slot_image[s >> 2][pos + 1]) begin
          if (k == 0) begin
            r.found = 1'b1;
            if (w.func == FUNC_TAKE_VAL) r.value_bit = slot_image[s >> 2][pos];
            else r.slot_index = SLOT_W'(s);
            slot_image[s >> 2][pos + 1] = 1'b1;
            break;
          end
          k--;
        end
      end
      expected_takes.push_back(r);
    end
  endtask

  task automatic queue_op(input logic [1:0] f, input int a, input int d, input int k);
    slot_word_t w;
    w.func = f;
    w.byte_address = ADDR_W'(a);
    w.load_byte = 8'(d);
    w.rank = SLOT_W'(k);
    queue_word(w);
  endtask

  task automatic queue_random_word();
    int r, free_now;
    r = $urandom_range(99);
    free_now = unused_slots();
    if (r < 40) begin
      if (valid_slot_limit > 0 && $urandom_range(99) < 85)
        queue_op(FUNC_LOAD, $urandom_range((valid_slot_limit - 1) / 4), $urandom, 0);
      else
        queue_op(FUNC_LOAD, $urandom, $urandom, 0);
    end else if (r < 95) begin
      queue_op(r < 67 ? FUNC_TAKE_VAL : FUNC_TAKE_IDX, 0, 0,
               (free_now > 0 && $urandom_range(99) < 75) ?
               $urandom_range(free_now - 1) : $urandom);
    end else begin
      queue_op(FUNC_IGNORED, $urandom, $urandom, $urandom);
    end
  endtask

  // Waits until every word is sent and checked, then lets the unit settle.
  task automatic drain();
    while (pending_words.size() != 0 || expected_takes.size() != 0) @(posedge clk);
    repeat (270) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_slot_count(input int value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_slot_count <= SC_W'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    valid_slot_limit = (value > TOTAL_SLOTS) ? TOTAL_SLOTS : value;
  endtask

  // Driver: keeps a word on the inputs until the unit takes it.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_func <= FUNC_LOAD;
      in_byte_address <= '0;
      in_load_byte <= '0;
      in_rank <= '0;
    end else begin
      if (start && !busy) begin
        void'(pending_words.pop_front());
        words_sent++;
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (pending_words.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        start <= 1'b1;
        in_func <= pending_words[0].func;
        in_byte_address <= pending_words[0].byte_address;
        in_load_byte <= pending_words[0].load_byte;
        in_rank <= pending_words[0].rank;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobed word is compared with the oldest expected take.
  always @(posedge clk) begin
    take_result_t e;
    if (rst_n && out_strobe) begin
      if (expected_takes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word: found=%0d value=%0d index=%0d",
                                       out_found, out_value_bit, out_slot_index);
      end else begin
        e = expected_takes.pop_front();
        takes_checked++;
        if (e.found) takes_found++;
        if (out_found !== e.found || out_value_bit !== e.value_bit ||
            out_slot_index !== e.slot_index) begin
          mismatches++;
          if (mismatches <= 10)
            $display("take %0d mismatch: expected found=%0d value=%0d index=%0d, got %0d %0d %0d",
                     takes_checked, e.found, e.value_bit, e.slot_index,
                     out_found, out_value_bit, out_slot_index);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("kth_unused_slot_take_unit test failed");
      $finish;
    end
  end

  initial begin
    int phase_counts[8] = '{4096, 1, 4095, 8191, 0, 5, 2049, 700};
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_slot_count = '0;
    sender_idle_pct = 8;
    valid_slot_limit = TOTAL_SLOTS;
    foreach (slot_image[i]) slot_image[i] = 8'h00;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Every byte is loaded before any take, so no take reads an unwritten byte.
    for (int a = 0; a < STORE_BYTES; a++) queue_op(FUNC_LOAD, a, $urandom, 0);
    queue_op(FUNC_LOAD, 0, 8'hFF, 0);
    queue_op(FUNC_LOAD, STORE_BYTES - 1, 8'hFF, 0);
    queue_op(FUNC_TAKE_VAL, 0, 0, 0);
    queue_op(FUNC_TAKE_IDX, 0, 0, 4095);
    queue_op(FUNC_TAKE_IDX, 0, 0, 4095);
    queue_op(FUNC_TAKE_VAL, 0, 0, 4094);
    queue_op(FUNC_IGNORED, 1023, 8'hFF, 4095);
    queue_op(FUNC_LOAD, STORE_BYTES - 1, 8'h00, 0);
    queue_op(FUNC_TAKE_IDX, 0, 0, 4094);
    queue_op(FUNC_LOAD, 0, 8'hAA, 0);
    queue_op(FUNC_TAKE_VAL, 0, 0, 0);
    queue_op(FUNC_TAKE_IDX, 0, 0, 1);
    drain();

    for (int p = 0; p < 8; p++) begin
      write_slot_count(phase_counts[p]);
      sender_idle_pct = (p < 4) ? 55 : 0;
      // A too-large rank and a take at the top of the valid range in every setting.
      queue_op(FUNC_TAKE_IDX, 0, 0, 4095);
      if (unused_slots() > 0) queue_op(FUNC_TAKE_IDX, 0, 0, unused_slots() - 1);
      for (int i = 0; i < 12; i++) queue_random_word();
      drain();
    end

    $display("%0d words sent, %0d takes checked (%0d found) over 8 slot count settings",
             words_sent, takes_checked, takes_found);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0 && expected_takes.size() == 0)
      $display("kth_unused_slot_take_unit test passed");
    else
      $display("kth_unused_slot_take_unit test failed");
    $finish;
  end

endmodule
